/* design/mps_pkg.sv */
// Package for matrix_power_by_squaring: payload structs, FSM states, constants, saturating math.
// No dependencies.
package mps_pkg;

  typedef struct packed {
    logic signed [31:0] element;
    logic [15:0]        exponent;
    logic               last_element;
  } mps_in_t;

  typedef struct packed {
    logic signed [31:0] result_element;
    logic [2:0]         row_index;
    logic [2:0]         column_index;
    logic               last_result;
  } mps_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_COPY,
    ST_EMIT
  } mps_state_t;

  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // arithmetic shift of the full product by 24, then clamp to 32 bits
  function automatic logic [31:0] q24_sat(input logic signed [63:0] p);
    logic signed [39:0] s;
    begin
      s = 40'(p >>> 24);
      if (s > 40'sh007FFFFFFF)       q24_sat = SAT_MAX;
      else if (s < -40'sh0080000000) q24_sat = SAT_MIN;
      else                           q24_sat = s[31:0];
    end
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] s;
    begin
      s = 33'(signed'(a)) + 33'(signed'(b));
      if (s > 33'sh07FFFFFFF)       add_sat = SAT_MAX;
      else if (s < -33'sh080000000) add_sat = SAT_MIN;
      else                          add_sat = s[31:0];
    end
  endfunction

endpackage

/* design/mps_mac.sv */
// Shared multiply-accumulate for matrix_power_by_squaring.
// Depends on mps_pkg. Stage 1 registers the product, stage 2 saturating-adds.
module mps_mac (
  input  logic        clk,
  input  logic        op_valid,
  input  logic        op_first,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] acc
);
  import mps_pkg::*;

  logic signed [63:0] prod_r, prod_nxt;
  logic               vld_r, first_r;
  logic [31:0]        acc_r, acc_nxt;

  assign prod_nxt = 64'(signed'(op_a)) * 64'(signed'(op_b));

  always_comb begin
    acc_nxt = acc_r;
    if (vld_r) acc_nxt = add_sat(first_r ? 32'd0 : acc_r, q24_sat(prod_r));
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    vld_r   <= op_valid;
    first_r <= op_first;
    acc_r   <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

/* design/matrix_power_by_squaring.sv */
// Top level of matrix_power_by_squaring: APB register, sequencer, three stores.
// Depends on mps_pkg and mps_mac.
//
// Elements are loaded one per start transaction; the one marked last_element
// starts the power. The identity is first written into the accumulator.
// A matrix product uses one shared multiplier and one store read per operand
// per cycle, drains each element to scratch, then copies scratch back; up to
// two products per exponent bit. Then n*n results leave one per cycle on
// out_valid, which cannot be stalled. busy is high from the cycle after the
// last element and falls as the final result appears.
module matrix_power_by_squaring #(
  parameter int MAX_SIZE      = 8,
  parameter int EXPONENT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mps_pkg::mps_in_t  in_data,
  output logic              out_valid,
  output mps_pkg::mps_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [0:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mps_pkg::*;

  localparam int CELLS = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(MAX_SIZE);

  logic [3:0] size_r;
  assign pready = 1'b1;
  assign prdata = {28'd0, size_r};
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 4'd2;
    else if (psel && penable && pwrite && paddr == 1'b0) size_r <= pwdata[3:0];
  end

  logic [IW:0] n;
  always_comb begin
    if (size_r < 4'd2) n = (IW+1)'(2);
    else if (32'(size_r) > MAX_SIZE) n = (IW+1)'(MAX_SIZE);
    else n = (IW+1)'(size_r);
  end
  logic [AW:0] cells;
  assign cells = (AW+1)'(n) * (AW+1)'(n);

  // memories
  logic [31:0] base_mem [CELLS];
  logic [31:0] acc_mem  [CELLS];
  logic [31:0] scr_mem  [CELLS];
  logic [31:0] base_q, acc_q, scr_q, b2_q;
  logic        base_we, acc_we, scr_we;
  logic [AW-1:0] base_wa, acc_wa, scr_wa, ra_a, ra_b, scr_ra;
  logic [31:0] base_wd, acc_wd, scr_wd;

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    base_q <= base_mem[ra_a];
    b2_q   <= base_mem[ra_b];
  end
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_q <= acc_mem[ra_a];
  end
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    scr_q <= scr_mem[scr_ra];
  end

  mps_state_t state_r, state_nxt;
  logic [AW:0] lpos_r, lpos_nxt;
  logic [EXPONENT_BITS-1:0] exp_r, exp_nxt;
  logic sq_r, sq_nxt;            // current product is the squaring
  logic [IW:0] r_r, r_nxt, c_r, c_nxt, i_r, i_nxt;
  logic [AW:0] k_r, k_nxt;
  logic        rd_r;             // copy/emit read issued last cycle
  logic [AW:0] kd_r;
  logic [IW:0] rd_row_r, rd_col_r;
  // multiply issue and writeback tracking
  logic        iss_v, iss_first, v1_r, last1_r;
  logic [AW-1:0] wa1_r, wa2_r, wa3_r;
  logic        lastx1_r, lastx2_r, wbx_r;
  logic [31:0] mac_acc;
  logic        out_v_r;
  mps_out_t    out_r;

  mps_mac u_mac (
    .clk(clk), .op_valid(v1_r), .op_first(last1_r),
    .op_a(sq_r ? base_q : acc_q), .op_b(b2_q), .acc(mac_acc)
  );

  function automatic logic [AW-1:0] idx(input logic [IW:0] a, input logic [IW:0] b,
                                        input logic [IW:0] m);
    idx = AW'(a) * AW'(m) + AW'(b);
  endfunction

  always_comb begin
    state_nxt = state_r; lpos_nxt = lpos_r; exp_nxt = exp_r; sq_nxt = sq_r;
    r_nxt = r_r; c_nxt = c_r; i_nxt = i_r; k_nxt = k_r;
    base_we = 1'b0; base_wa = '0; base_wd = in_data.element;
    acc_we = 1'b0; acc_wa = '0; acc_wd = '0;
    scr_we = wbx_r; scr_wa = wa3_r; scr_wd = mac_acc;
    ra_a = idx(r_r, i_r, n); ra_b = idx(i_r, c_r, n); scr_ra = k_r[AW-1:0];
    iss_v = 1'b0; iss_first = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          base_we = 1'b1;
          base_wa = (lpos_r >= cells) ? '0 : lpos_r[AW-1:0];
          lpos_nxt = (lpos_r >= cells) ? (AW+1)'(1) : lpos_r + 1'b1;
          if (lpos_nxt >= cells) lpos_nxt = '0;
          if (in_data.last_element) begin
            lpos_nxt = '0;
            exp_nxt = EXPONENT_BITS'(in_data.exponent);
            k_nxt = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        acc_we = 1'b1; acc_wa = k_r[AW-1:0];
        acc_wd = (r_r == c_r) ? ONE_Q24 : 32'd0;
        k_nxt = k_r + 1'b1;
        c_nxt = c_r + 1'b1;
        if (c_r == n - 1'b1) begin c_nxt = '0; r_nxt = r_r + 1'b1; end
        if (k_r == cells - 1'b1) begin
          r_nxt = '0; c_nxt = '0; i_nxt = '0;
          if (exp_r == '0) begin state_nxt = ST_EMIT; k_nxt = '0; end
          else begin sq_nxt = ~exp_r[0]; state_nxt = ST_MUL; end
        end
      end
      ST_MUL: begin
        // i runs 0..n-1 issuing, then n..n+2 drain for the writeback
        if (i_r < n) begin
          iss_v = 1'b1; iss_first = (i_r == '0);
        end
        i_nxt = i_r + 1'b1;
        if (i_r == n + 2'd2) begin
          i_nxt = '0; c_nxt = c_r + 1'b1;
          if (c_r == n - 1'b1) begin
            c_nxt = '0; r_nxt = r_r + 1'b1;
            if (r_r == n - 1'b1) begin
              r_nxt = '0; k_nxt = '0; state_nxt = ST_COPY;
            end
          end
        end
      end
      ST_COPY: begin
        if (k_r < cells) k_nxt = k_r + 1'b1;
        if (rd_r) begin
          if (sq_r) begin base_we = 1'b1; base_wa = kd_r[AW-1:0]; base_wd = scr_q; end
          else begin acc_we = 1'b1; acc_wa = kd_r[AW-1:0]; acc_wd = scr_q; end
          if (kd_r == cells - 1'b1) begin
            k_nxt = '0;
            if (!sq_r) begin
              if ((exp_r >> 1) != '0) begin sq_nxt = 1'b1; state_nxt = ST_MUL; end
              else state_nxt = ST_EMIT;
            end else begin
              exp_nxt = exp_r >> 1;
              sq_nxt = ~exp_nxt[0];
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_EMIT: begin
        ra_a = k_r[AW-1:0];
        if (k_r < cells) begin
          k_nxt = k_r + 1'b1;
          c_nxt = c_r + 1'b1;
          if (c_r == n - 1'b1) begin c_nxt = '0; r_nxt = r_r + 1'b1; end
        end
        if (rd_r && kd_r == cells - 1'b1) begin
          state_nxt = ST_IDLE; k_nxt = '0; r_nxt = '0; c_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic rd_nxt;
  assign rd_nxt = (state_r == ST_COPY || state_r == ST_EMIT) && k_r < cells
                  && !(rd_r && kd_r == cells - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; lpos_r <= '0; r_r <= '0; c_r <= '0; i_r <= '0; k_r <= '0;
      rd_r <= 1'b0; v1_r <= 1'b0; out_v_r <= 1'b0;
      exp_r <= '0; sq_r <= 1'b0;
    end else begin
      state_r <= state_nxt; lpos_r <= lpos_nxt; exp_r <= exp_nxt; sq_r <= sq_nxt;
      r_r <= r_nxt; c_r <= c_nxt; i_r <= i_nxt; k_r <= k_nxt;
      rd_r <= rd_nxt;
      v1_r <= iss_v;
      out_v_r <= rd_r && state_r == ST_EMIT;
    end
  end

  logic last_iss;
  assign last_iss = iss_v && (i_r == n - 1'b1);
  always_ff @(posedge clk) begin
    kd_r <= k_r;
    rd_row_r <= r_r; rd_col_r <= c_r;
    last1_r <= iss_first;
    wa1_r <= idx(r_r, c_r, n);
    wa2_r <= wa1_r; wa3_r <= wa2_r;
    out_r.result_element <= acc_q;
    out_r.row_index      <= 3'(rd_row_r);
    out_r.column_index   <= 3'(rd_col_r);
    out_r.last_result    <= (kd_r == cells - 1'b1);
  end

  // last-of-dot tracking: lastx1_r, lastx2_r and wbx_r carry the final issue so
  // wbx_r is high while the finished sum sits on mac_acc, alongside wa3_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin lastx1_r <= 1'b0; lastx2_r <= 1'b0; end
    else begin lastx1_r <= last_iss; lastx2_r <= lastx1_r; end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) wbx_r <= 1'b0;
    else wbx_r <= lastx2_r;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result outside computation");
  a_lpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    lpos_r <= (AW+1)'(CELLS)) else $error("load position out of range");
  a_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wbx_r |-> state_r == ST_MUL || state_r == ST_COPY) else $error("stray writeback");
`endif
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for matrix_power_by_squaring: APB size register,
// element loading and result stream, checked against a built-in predictor.
// Depends on mps_pkg and the matrix_power_by_squaring RTL.
`timescale 1ns / 1ps

class mps_scoreboard;
  logic [31:0] base_m[64];
  logic [31:0] acc_m[64];
  bit          loaded[64];
  int unsigned load_pos;
  logic [3:0]  size_reg;
  mps_pkg::mps_out_t pending_q[$];
  int unsigned errors;

  function new();
    load_pos = 0;
    size_reg = 4'd2;
    errors   = 0;
    foreach (loaded[i]) loaded[i] = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  function int unsigned active_n();
    if (size_reg < 2) return 2;
    if (size_reg > 8) return 8;
    return size_reg;
  endfunction

  // an item sent now with last set would leave no unloaded slot in use
  function bit can_end_early();
    int unsigned cells, p;
    cells = active_n() * active_n();
    p = (load_pos >= cells) ? 0 : load_pos;
    for (int unsigned k = p + 1; k < cells; k++)
      if (!loaded[k]) return 0;
    return 1;
  endfunction

  function int unsigned next_slot();
    int unsigned cells;
    cells = active_n() * active_n();
    return (load_pos >= cells) ? 0 : load_pos;
  endfunction

  function logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // square = 1: base := base*base, else acc := acc*base
  function void mat_mul(bit square);
    logic [31:0] a[64];
    logic [31:0] b[64];
    logic [31:0] s[64];
    int unsigned n;
    longint pa, pb, sum;
    n = active_n();
    if (square) a = base_m;
    else a = acc_m;
    b = base_m;
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++) begin
        sum = 0;
        for (int unsigned i = 0; i < n; i++) begin
          pa = $signed(a[r*n+i]);
          pb = $signed(b[i*n+c]);
          sum = $signed(sat(sum + $signed(sat((pa * pb) >>> 24))));
        end
        s[r*n+c] = sum[31:0];
      end
    for (int unsigned k = 0; k < n * n; k++)
      if (square) base_m[k] = s[k];
      else acc_m[k] = s[k];
  endfunction

  function void note_input(mps_pkg::mps_in_t d);
    int unsigned n, cells;
    logic [15:0] e;
    mps_pkg::mps_out_t o;
    n = active_n();
    cells = n * n;
    if (load_pos >= cells) load_pos = 0;
    base_m[load_pos] = d.element;
    loaded[load_pos] = 1;
    load_pos++;
    if (load_pos >= cells) load_pos = 0;
    if (!d.last_element) return;
    load_pos = 0;
    e = d.exponent;
    for (int unsigned k = 0; k < cells; k++)
      acc_m[k] = (k / n == k % n) ? mps_pkg::ONE_Q24 : 32'h0;
    while (e != 0) begin
      if (e[0]) mat_mul(0);
      e = e >> 1;
      if (e != 0) mat_mul(1);
    end
    for (int unsigned k = 0; k < cells; k++) begin
      o.result_element = acc_m[k];
      o.row_index      = 3'(k / n);
      o.column_index   = 3'(k % n);
      o.last_result    = (k == cells - 1);
      pending_q.push_back(o);
    end
  endfunction

  task check_result(mps_pkg::mps_out_t got);
    mps_pkg::mps_out_t want;
    if (pending_q.size() == 0) begin
      report($sformatf("result with nothing expected: %h", got));
      return;
    end
    want = pending_q.pop_front();
    if (got.result_element !== want.result_element)
      report($sformatf("element got %h want %h", got.result_element, want.result_element));
    if (got.row_index !== want.row_index)
      report($sformatf("row got %0d want %0d", got.row_index, want.row_index));
    if (got.column_index !== want.column_index)
      report($sformatf("column got %0d want %0d", got.column_index, want.column_index));
    if (got.last_result !== want.last_result)
      report($sformatf("last got %b want %b", got.last_result, want.last_result));
  endtask
endclass

module tb_top;
  import mps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned ITEM_TARGET = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  mps_in_t     in_data = '0;
  logic        out_valid;
  mps_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mps_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   item_count = 0;
  bit            idling = 1'b1;

  matrix_power_by_squaring u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function logic [31:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
    endcase
  endfunction

  function logic [15:0] pick_exponent();
    return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
  endfunction

  // most items one matrix can take at a given size value
  function int unsigned span_of(logic [3:0] s);
    int unsigned n;
    n = (s < 2) ? 2 : (s > 8) ? 8 : s;
    return n * n + 5;
  endfunction

  task send_item(logic [31:0] el, logic [15:0] ex, logic last);
    mps_in_t d;
    d.element = el;
    d.exponent = ex;
    d.last_element = last;
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(d);
    item_count++;
  endtask

  // register writes only once the block has drained
  task write_size(logic [31:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 1'b0; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.size_reg = v[3:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] !== v[3:0])
      sb.report($sformatf("size read back %h want %h", prdata[3:0], v[3:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // one matrix: optional stray elements, optional early finish
  task send_matrix(bit noise, bit early);
    int unsigned cells;
    cells = sb.active_n() * sb.active_n();
    if (noise)
      repeat ($urandom_range(1, 5))
        send_item(pick_element(), 16'($urandom), 1'b0);
    while (sb.next_slot() != cells - 1 &&
           !(early && sb.can_end_early() && $urandom_range(0, 7) == 0))
      send_item(pick_element(), 16'($urandom), 1'b0);
    send_item(pick_element(), pick_exponent(), 1'b1);
  endtask

  initial begin
    logic [31:0] sz;
    int unsigned roll;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(32'd2);
    // extremes, exponent zero gives identity
    send_item(32'h7FFF_FFFF, 16'h0, 1'b0);
    send_item(32'h8000_0000, 16'h0, 1'b0);
    send_item(32'h0, 16'h0, 1'b0);
    send_item(ONE_Q24, 16'h0, 1'b1);
    // every exponent bit set
    send_item(ONE_Q24, 16'hFFFF, 1'b0);
    send_item(32'h0000_1000, 16'hFFFF, 1'b0);
    send_item(32'hFFFF_F000, 16'hFFFF, 1'b0);
    send_item(ONE_Q24, 16'hFFFF, 1'b1);
    // early last: remaining slots hold the squares left behind
    send_item(32'h0180_0000, 16'h1, 1'b1);
    // too many elements wrap onto slot 0
    send_item(32'h0040_0000, 16'h0, 1'b0);
    send_item(32'hFF00_0000, 16'h0, 1'b0);
    send_item(32'h0200_0000, 16'h0, 1'b0);
    send_item(32'h00C0_0000, 16'h0, 1'b0);
    send_item(32'hFFC0_0000, 16'h3, 1'b1);
    // load position beyond the new size restarts at 0
    write_size(32'd3);
    repeat (5) send_item(pick_element(), 16'($urandom), 1'b0);
    write_size(32'd2);
    send_item(pick_element(), 16'h0, 1'b0);
    send_item(pick_element(), 16'h0, 1'b0);
    send_item(pick_element(), 16'h0, 1'b0);
    send_item(pick_element(), 16'h5, 1'b1);

    while (item_count < ITEM_TARGET) begin
      roll = $urandom_range(0, 19);
      case (roll)
        0: sz = 32'd0;
        1: sz = 32'd1;
        2: sz = 32'd8;
        3: sz = $urandom_range(9, 15);
        default: sz = $urandom_range(2, 5);
      endcase
      // near the end keep matrices small so the item count stays close
      if (item_count + span_of(sz[3:0]) > ITEM_TARGET + 8) sz = 32'd2;
      sz[31:4] = 28'($urandom);
      write_size(sz);
      repeat ($urandom_range(1, 3)) begin
        if (item_count + span_of(sb.size_reg) <= ITEM_TARGET + 8) begin
          if (item_count > 90) idling = 1'b0;
          roll = $urandom_range(0, 19);
          send_matrix(roll < 3, roll >= 3 && roll < 6);
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

/* matrix_power_by_squaring.f */
design/mps_pkg.sv
design/mps_mac.sv
design/matrix_power_by_squaring.sv
tb/tb_top.sv
